// ===== hw/rtl/smr_pkg.sv =====
`default_nettype none

package smr_pkg;

  localparam int unsigned SAMPLE_BITS = 24;
  localparam int unsigned COUNT_BITS  = 17;
  localparam int unsigned MAX_SAMPLES = 65536;
  localparam int unsigned SUM_BITS    = 40;
  localparam int unsigned SQ_BITS     = 63;

  localparam int unsigned MUL_A_BITS   = 64;
  localparam int unsigned MUL_B_BITS   = 40;
  localparam int unsigned MUL_P_BITS   = MUL_A_BITS + MUL_B_BITS;
  localparam int unsigned MUL_CNT_BITS = 6;

  localparam int unsigned DIV_N_BITS   = 80;
  localparam int unsigned DIV_D_BITS   = 34;
  localparam int unsigned DIV_CNT_BITS = 7;

  localparam int unsigned ROOT_IN_BITS  = 64;
  localparam int unsigned ROOT_BITS     = ROOT_IN_BITS / 2;
  localparam int unsigned ROOT_REM_BITS = ROOT_BITS + 2;
  localparam int unsigned ROOT_CNT_BITS = 5;

  localparam logic [SAMPLE_BITS-1:0] EMPTY_CODE = 24'hFC6F00;

  typedef logic [MUL_A_BITS-1:0]   mul_a_t;
  typedef logic [MUL_B_BITS-1:0]   mul_b_t;
  typedef logic [MUL_P_BITS-1:0]   mul_p_t;
  typedef logic [DIV_N_BITS-1:0]   div_n_t;
  typedef logic [DIV_D_BITS-1:0]   div_d_t;
  typedef logic [COUNT_BITS-1:0]   count_t;
  typedef logic [SAMPLE_BITS-1:0]  sample_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_OVER  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQR,
    ST_FIN,
    ST_MEAN,
    ST_NSQ,
    ST_SSQ,
    ST_NN,
    ST_VAR,
    ST_ROOT,
    ST_EMIT
  } state_e;

endpackage

`default_nettype wire

// ===== hw/rtl/smr_in_if.sv =====
`default_nettype none

interface smr_in_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [smr_pkg::SAMPLE_BITS-1:0]  sample;
  logic                                    has_sample;
  logic                                    last;

  modport source (output valid, output sample, output has_sample, output last, input ready);
  modport sink   (input valid, input sample, input has_sample, input last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/smr_out_if.sv =====
`default_nettype none

interface smr_out_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [smr_pkg::SAMPLE_BITS-1:0]  mean_value;
  logic signed [smr_pkg::SAMPLE_BITS-1:0]  spread_value;
  logic [1:0]                              status;
  logic [smr_pkg::COUNT_BITS-1:0]          sample_count;

  modport source (output valid, output mean_value, output spread_value, output status,
                  output sample_count, input ready);
  modport sink   (input valid, input mean_value, input spread_value, input status,
                  input sample_count, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/smr_mul.sv =====
`default_nettype none

module smr_mul (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  start_i,
  input  smr_pkg::mul_a_t      mcand_i,
  input  smr_pkg::mul_b_t      mplier_i,
  output logic                 done_o,
  output smr_pkg::mul_p_t      prod_o
);

  localparam logic [smr_pkg::MUL_CNT_BITS-1:0] CntLast =
    smr_pkg::MUL_CNT_BITS'(smr_pkg::MUL_B_BITS - 1);

  logic                              busy_q;
  logic                              done_q;
  logic [smr_pkg::MUL_CNT_BITS-1:0]  cnt_q;
  smr_pkg::mul_a_t                   mcand_q;
  smr_pkg::mul_a_t                   acc_q;
  smr_pkg::mul_b_t                   low_q;
  logic [smr_pkg::MUL_A_BITS:0]      sum;

  assign sum = {1'b0, acc_q} + {1'b0, (low_q[0] ? mcand_q : smr_pkg::mul_a_t'(0))};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CntLast) && !start_i;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CntLast) begin
          busy_q <= 1'b0;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcand_q <= mcand_i;
      acc_q   <= '0;
      low_q   <= mplier_i;
    end else if (busy_q) begin
      acc_q <= sum[smr_pkg::MUL_A_BITS:1];
      low_q <= {sum[0], low_q[smr_pkg::MUL_B_BITS-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = {acc_q, low_q};

endmodule

`default_nettype wire

// ===== hw/rtl/smr_div.sv =====
`default_nettype none

module smr_div (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  start_i,
  input  smr_pkg::div_n_t      dividend_i,
  input  smr_pkg::div_d_t      divisor_i,
  output logic                 done_o,
  output smr_pkg::div_n_t      quot_o
);

  localparam logic [smr_pkg::DIV_CNT_BITS-1:0] CntLast =
    smr_pkg::DIV_CNT_BITS'(smr_pkg::DIV_N_BITS - 1);

  logic                              busy_q;
  logic                              done_q;
  logic [smr_pkg::DIV_CNT_BITS-1:0]  cnt_q;
  smr_pkg::div_d_t                   dvs_q;
  smr_pkg::div_d_t                   rem_q;
  smr_pkg::div_n_t                   quo_q;
  logic [smr_pkg::DIV_D_BITS:0]      shifted;
  logic [smr_pkg::DIV_D_BITS:0]      diff;
  logic                              ge;

  assign shifted = {rem_q, quo_q[smr_pkg::DIV_N_BITS-1]};
  assign ge      = shifted >= {1'b0, dvs_q};
  assign diff    = shifted - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CntLast) && !start_i;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CntLast) begin
          busy_q <= 1'b0;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvs_q <= divisor_i;
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[smr_pkg::DIV_D_BITS-1:0] : shifted[smr_pkg::DIV_D_BITS-1:0];
      quo_q <= {quo_q[smr_pkg::DIV_N_BITS-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

`default_nettype wire

// ===== hw/rtl/sample_mean_and_rms_unit.sv =====
`default_nettype none

// Accumulates signed Q15.8 samples into a count, a sum and a sum of squares, and on the
// item that closes the set delivers the mean (truncated toward zero) and the population
// standard deviation (floor root), both Q15.8, with status and sample count. Items are taken
// one at a time: an item with a sample holds off the next until the 40-step shift-add
// multiplier has squared it. Closing a set runs two 80-step bit-serial divisions (mean
// and variance), three 40-step multiplications on the same multiplier and a 32-step
// two-bits-per-cycle square root. An empty set returns -913 for both values with empty
// status; samples beyond 65536 in a set are dropped and flagged in the status. The result
// sits in an output register, so the next set starts while the result waits; a second
// result waits until the first is taken.
module sample_mean_and_rms_unit (
  input  wire          clk_i,
  input  wire          rst_ni,
  smr_in_if.sink       in_i,
  smr_out_if.source    out_o
);

  localparam smr_pkg::count_t CountMax = smr_pkg::COUNT_BITS'(smr_pkg::MAX_SAMPLES);
  localparam logic [smr_pkg::ROOT_CNT_BITS-1:0] RootLast =
    smr_pkg::ROOT_CNT_BITS'(smr_pkg::ROOT_BITS - 1);

  smr_pkg::state_e                     state_q, state_d;
  smr_pkg::count_t                     count_q;
  logic [smr_pkg::SUM_BITS-1:0]        sum_q;
  logic [smr_pkg::SQ_BITS-1:0]         sumsq_q;
  logic                                ovf_q;
  logic                                last_q;

  logic [smr_pkg::SUM_BITS-1:0]        smag_q;
  logic                                neg_q;
  smr_pkg::sample_t                    mean_q;
  smr_pkg::div_n_t                     a_q;
  smr_pkg::div_n_t                     d_q;
  logic [smr_pkg::ROOT_IN_BITS-1:0]    x_q;
  logic [smr_pkg::ROOT_REM_BITS-1:0]   r_q;
  logic [smr_pkg::ROOT_BITS-1:0]       root_q;
  logic [smr_pkg::ROOT_CNT_BITS-1:0]   rcnt_q;

  logic                                out_valid_q;
  smr_pkg::sample_t                    out_mean_q;
  smr_pkg::sample_t                    out_spread_q;
  smr_pkg::status_e                    out_status_q;
  smr_pkg::count_t                     out_count_q;

  logic                                in_fire;
  logic                                take;
  logic                                emit_load;
  smr_pkg::sample_t                    mag;
  logic [smr_pkg::SUM_BITS-1:0]        sum_abs;
  smr_pkg::div_n_t                     sq_prod;

  logic                                mul_start;
  smr_pkg::mul_a_t                     mul_a;
  smr_pkg::mul_b_t                     mul_b;
  logic                                mul_done;
  smr_pkg::mul_p_t                     mul_prod;
  logic                                div_start;
  smr_pkg::div_n_t                     div_dvd;
  smr_pkg::div_d_t                     div_dvs;
  logic                                div_done;
  smr_pkg::div_n_t                     div_quot;

  logic [smr_pkg::ROOT_REM_BITS+1:0]   rr;
  logic [smr_pkg::ROOT_REM_BITS+1:0]   rt;
  logic [smr_pkg::ROOT_REM_BITS+1:0]   rdiff;
  logic                                rge;

  smr_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .mcand_i  (mul_a),
    .mplier_i (mul_b),
    .done_o   (mul_done),
    .prod_o   (mul_prod)
  );

  smr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign in_i.ready = (state_q == smr_pkg::ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign take       = in_fire && in_i.has_sample && (count_q != CountMax);
  assign emit_load  = (state_q == smr_pkg::ST_EMIT) && (!out_valid_q || out_o.ready);
  assign mag        = in_i.sample[smr_pkg::SAMPLE_BITS-1]
                      ? (smr_pkg::sample_t'(0) - smr_pkg::sample_t'(in_i.sample))
                      : smr_pkg::sample_t'(in_i.sample);
  assign sum_abs    = sum_q[smr_pkg::SUM_BITS-1] ? ('0 - sum_q) : sum_q;
  assign sq_prod    = mul_prod[smr_pkg::DIV_N_BITS-1:0];

  assign rr    = {r_q, x_q[smr_pkg::ROOT_IN_BITS-1 -: 2]};
  assign rt    = {2'b00, root_q, 2'b01};
  assign rge   = rr >= rt;
  assign rdiff = rr - rt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= smr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    unique case (state_q)
      smr_pkg::ST_IDLE: begin
        if (take) begin
          mul_start = 1'b1;
          mul_a     = smr_pkg::MUL_A_BITS'(mag);
          mul_b     = smr_pkg::MUL_B_BITS'(mag);
          state_d   = smr_pkg::ST_SQR;
        end else if (in_fire && in_i.last) begin
          state_d = smr_pkg::ST_FIN;
        end
      end
      smr_pkg::ST_SQR: begin
        if (mul_done) begin
          state_d = last_q ? smr_pkg::ST_FIN : smr_pkg::ST_IDLE;
        end
      end
      smr_pkg::ST_FIN: begin
        if (count_q == '0) begin
          state_d = smr_pkg::ST_EMIT;
        end else begin
          div_start = 1'b1;
          div_dvd   = smr_pkg::DIV_N_BITS'(sum_abs);
          div_dvs   = smr_pkg::DIV_D_BITS'(count_q);
          state_d   = smr_pkg::ST_MEAN;
        end
      end
      smr_pkg::ST_MEAN: begin
        if (div_done) begin
          mul_start = 1'b1;
          mul_a     = smr_pkg::MUL_A_BITS'(sumsq_q);
          mul_b     = smr_pkg::MUL_B_BITS'(count_q);
          state_d   = smr_pkg::ST_NSQ;
        end
      end
      smr_pkg::ST_NSQ: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = smr_pkg::MUL_A_BITS'(smag_q);
          mul_b     = smag_q;
          state_d   = smr_pkg::ST_SSQ;
        end
      end
      smr_pkg::ST_SSQ: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = smr_pkg::MUL_A_BITS'(count_q);
          mul_b     = smr_pkg::MUL_B_BITS'(count_q);
          state_d   = smr_pkg::ST_NN;
        end
      end
      smr_pkg::ST_NN: begin
        if (mul_done) begin
          div_start = 1'b1;
          div_dvd   = d_q;
          div_dvs   = mul_prod[smr_pkg::DIV_D_BITS-1:0];
          state_d   = smr_pkg::ST_VAR;
        end
      end
      smr_pkg::ST_VAR: begin
        if (div_done) begin
          state_d = smr_pkg::ST_ROOT;
        end
      end
      smr_pkg::ST_ROOT: begin
        if (rcnt_q == RootLast) begin
          state_d = smr_pkg::ST_EMIT;
        end
      end
      smr_pkg::ST_EMIT: begin
        if (emit_load) begin
          state_d = smr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = smr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
      sumsq_q <= '0;
      ovf_q   <= 1'b0;
      last_q  <= 1'b0;
      rcnt_q  <= '0;
    end else begin
      if (emit_load) begin
        count_q <= '0;
        sum_q   <= '0;
        sumsq_q <= '0;
        ovf_q   <= 1'b0;
      end else begin
        if (in_fire) begin
          last_q <= in_i.last;
          if (in_i.has_sample) begin
            if (count_q == CountMax) begin
              ovf_q <= 1'b1;
            end else begin
              count_q <= count_q + 1'b1;
              sum_q   <= sum_q + {{(smr_pkg::SUM_BITS - smr_pkg::SAMPLE_BITS)
                                   {in_i.sample[smr_pkg::SAMPLE_BITS-1]}}, in_i.sample};
            end
          end
        end
        if ((state_q == smr_pkg::ST_SQR) && mul_done) begin
          sumsq_q <= sumsq_q + mul_prod[smr_pkg::SQ_BITS-1:0];
        end
      end
      if ((state_q == smr_pkg::ST_VAR) && div_done) begin
        rcnt_q <= '0;
      end else if (state_q == smr_pkg::ST_ROOT) begin
        rcnt_q <= rcnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == smr_pkg::ST_FIN) begin
      smag_q <= sum_abs;
      neg_q  <= sum_q[smr_pkg::SUM_BITS-1];
    end
    if ((state_q == smr_pkg::ST_MEAN) && div_done) begin
      mean_q <= neg_q ? (smr_pkg::sample_t'(0) - div_quot[smr_pkg::SAMPLE_BITS-1:0])
                      : div_quot[smr_pkg::SAMPLE_BITS-1:0];
    end
    if ((state_q == smr_pkg::ST_NSQ) && mul_done) begin
      a_q <= sq_prod;
    end
    if ((state_q == smr_pkg::ST_SSQ) && mul_done) begin
      d_q <= (a_q < sq_prod) ? '0 : (a_q - sq_prod);
    end
    if ((state_q == smr_pkg::ST_VAR) && div_done) begin
      x_q    <= div_quot[smr_pkg::ROOT_IN_BITS-1:0];
      r_q    <= '0;
      root_q <= '0;
    end else if (state_q == smr_pkg::ST_ROOT) begin
      x_q    <= {x_q[smr_pkg::ROOT_IN_BITS-3:0], 2'b00};
      r_q    <= rge ? rdiff[smr_pkg::ROOT_REM_BITS-1:0] : rr[smr_pkg::ROOT_REM_BITS-1:0];
      root_q <= {root_q[smr_pkg::ROOT_BITS-2:0], rge};
    end
    if (emit_load) begin
      if (count_q == '0) begin
        out_mean_q   <= smr_pkg::EMPTY_CODE;
        out_spread_q <= smr_pkg::EMPTY_CODE;
        out_status_q <= smr_pkg::STAT_EMPTY;
      end else begin
        out_mean_q   <= mean_q;
        out_spread_q <= root_q[smr_pkg::SAMPLE_BITS-1:0];
        out_status_q <= ovf_q ? smr_pkg::STAT_OVER : smr_pkg::STAT_OK;
      end
      out_count_q <= count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.mean_value   = out_mean_q;
  assign out_o.spread_value = out_spread_q;
  assign out_o.status       = out_status_q;
  assign out_o.sample_count = out_count_q;

  a_clear_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_load |=> (count_q == '0) && (sum_q == '0) && (sumsq_q == '0) && !ovf_q)
    else $error("accumulators not cleared after result");

  a_mul_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == smr_pkg::ST_SQR) || (state_q == smr_pkg::ST_NSQ) ||
                 (state_q == smr_pkg::ST_SSQ) || (state_q == smr_pkg::ST_NN))
    else $error("multiplier finished outside a waiting state");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == smr_pkg::ST_MEAN) || (state_q == smr_pkg::ST_VAR))
    else $error("divider finished outside a waiting state");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.status == smr_pkg::STAT_EMPTY)) |->
      (out_o.sample_count == '0) && (out_o.mean_value == smr_pkg::EMPTY_CODE))
    else $error("empty status with inconsistent result");

endmodule

`default_nettype wire

// ===== tb/sample_mean_and_rms_unit_tb.sv =====
module sample_mean_and_rms_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned       RUN_LIMIT   = 15_000_000;
  localparam int unsigned       HOLD_CYCLES = 4000;
  localparam int unsigned       TAIL_CYCLES = 500;
  localparam int unsigned       MAX_REPORTS = 10;
  localparam int unsigned       DIR_ROWS    = 21;
  localparam smr_pkg::sample_t  POS_FULL    = 24'h7FFFFF;
  localparam smr_pkg::sample_t  NEG_FULL    = 24'h800000;

  typedef enum int {
    PH_DIRECT,
    PH_FREE,
    PH_TX_IDLE,
    PH_RX_STALL,
    PH_BOTH,
    PH_HOLD
  } phase_e;

  typedef struct packed {
    smr_pkg::sample_t mean;
    smr_pkg::sample_t spread;
    smr_pkg::status_e status;
    smr_pkg::count_t  count;
  } stats_t;

  typedef struct packed {
    smr_pkg::sample_t smp;
    logic             has;
    logic             fin;
    logic             typed;
    stats_t           res;
  } stim_row_t;

  localparam stim_row_t DIR_TABLE [DIR_ROWS] = '{
    '{24'h000000, 1'b0, 1'b1, 1'b1, '{smr_pkg::EMPTY_CODE, smr_pkg::EMPTY_CODE,
                                      smr_pkg::STAT_EMPTY, smr_pkg::count_t'(0)}},
    '{24'h123456, 1'b0, 1'b0, 1'b0, '0},
    '{POS_FULL,   1'b1, 1'b1, 1'b1, '{POS_FULL, 24'h000000, smr_pkg::STAT_OK,
                                      smr_pkg::count_t'(1)}},
    '{NEG_FULL,   1'b1, 1'b1, 1'b1, '{NEG_FULL, 24'h000000, smr_pkg::STAT_OK,
                                      smr_pkg::count_t'(1)}},
    '{24'h000000, 1'b1, 1'b1, 1'b1, '{24'h000000, 24'h000000, smr_pkg::STAT_OK,
                                      smr_pkg::count_t'(1)}},
    '{NEG_FULL,   1'b1, 1'b0, 1'b0, '0},
    '{POS_FULL,   1'b1, 1'b1, 1'b0, '0},
    '{24'hFFFFFF, 1'b1, 1'b0, 1'b0, '0},
    '{24'hABCDEF, 1'b0, 1'b0, 1'b0, '0},
    '{24'hFFFFFE, 1'b1, 1'b0, 1'b0, '0},
    '{24'h5A5A5A, 1'b0, 1'b1, 1'b0, '0},
    '{24'hFFFFFF, 1'b0, 1'b1, 1'b1, '{smr_pkg::EMPTY_CODE, smr_pkg::EMPTY_CODE,
                                      smr_pkg::STAT_EMPTY, smr_pkg::count_t'(0)}},
    '{24'h000100, 1'b1, 1'b0, 1'b0, '0},
    '{24'h000200, 1'b1, 1'b0, 1'b0, '0},
    '{24'h000300, 1'b1, 1'b1, 1'b0, '0},
    '{24'h000001, 1'b1, 1'b1, 1'b1, '{24'h000001, 24'h000000, smr_pkg::STAT_OK,
                                      smr_pkg::count_t'(1)}},
    '{POS_FULL,   1'b1, 1'b0, 1'b0, '0},
    '{POS_FULL,   1'b1, 1'b0, 1'b0, '0},
    '{POS_FULL,   1'b1, 1'b1, 1'b0, '0},
    '{24'h400000, 1'b1, 1'b0, 1'b0, '0},
    '{24'hC00000, 1'b1, 1'b1, 1'b0, '0}
  };

  logic clk;
  logic rst_n;

  smr_in_if  in_if ();
  smr_out_if out_if ();

  sample_mean_and_rms_unit dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  phase_e      phase = PH_DIRECT;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_count = 0;

  smr_pkg::count_t tally = '0;
  longint          sum_acc = 0;
  logic [63:0]     sq_acc = '0;
  logic            dropped = 1'b0;
  stats_t          pending_stats [$];

  logic        typed_pending = 1'b0;
  stats_t      typed_stats;

  function automatic logic [63:0] floor_sqrt64(input logic [63:0] x);
    logic [63:0] root;
    logic [63:0] probe;
    logic [63:0] rest;
    root  = '0;
    probe = 64'h4000_0000_0000_0000;
    rest  = x;
    while (probe > rest) probe = probe >> 2;
    while (probe != 0) begin
      if (rest >= root + probe) begin
        rest = rest - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  task automatic predict_stats(input smr_pkg::sample_t smp, input logic has, input logic fin);
    longint       v;
    logic [63:0]  mag;
    logic [127:0] scaled;
    logic [127:0] sq_of_sum;
    logic [127:0] spread_sq;
    stats_t       res;
    v = $signed(smp);
    if (has) begin
      if (tally >= smr_pkg::count_t'(smr_pkg::MAX_SAMPLES)) begin
        dropped = 1'b1;
      end else begin
        mag     = (v < 0) ? -v : v;
        tally   = tally + 1'b1;
        sum_acc = sum_acc + v;
        sq_acc  = sq_acc + mag * mag;
      end
    end
    if (fin) begin
      if (tally == 0) begin
        res = '{smr_pkg::EMPTY_CODE, smr_pkg::EMPTY_CODE, smr_pkg::STAT_EMPTY,
                smr_pkg::count_t'(0)};
      end else begin
        res.mean   = smr_pkg::sample_t'(sum_acc / longint'(tally));
        mag        = (sum_acc < 0) ? -sum_acc : sum_acc;
        scaled     = 128'(tally) * 128'(sq_acc);
        sq_of_sum  = 128'(mag) * 128'(mag);
        spread_sq  = (scaled < sq_of_sum) ? '0 : scaled - sq_of_sum;
        spread_sq  = spread_sq / (128'(tally) * 128'(tally));
        res.spread = smr_pkg::sample_t'(floor_sqrt64(spread_sq[63:0]));
        res.status = dropped ? smr_pkg::STAT_OVER : smr_pkg::STAT_OK;
        res.count  = tally;
      end
      if (typed_pending) begin
        res = typed_stats;
        typed_pending = 1'b0;
      end
      pending_stats.push_back(res);
      tally   = '0;
      sum_acc = 0;
      sq_acc  = '0;
      dropped = 1'b0;
    end
  endtask

  function automatic smr_pkg::sample_t pick_sample();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 12) return POS_FULL;
    if (r < 24) return NEG_FULL;
    if (r < 45) return smr_pkg::sample_t'($urandom_range(1024)) - smr_pkg::sample_t'(512);
    return smr_pkg::sample_t'($urandom());
  endfunction

  task automatic offer_item(input smr_pkg::sample_t smp, input logic has, input logic fin);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.sample     <= smp;
    in_if.has_sample <= has;
    in_if.last       <= fin;
    while (!in_if.ready) @(negedge clk);
    @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    do @(negedge clk); while (pending_stats.size() != 0);
  endtask

  task automatic send_random_sets(input int goal);
    int               sent;
    int               len;
    logic             flat;
    logic             close_on_sample;
    smr_pkg::sample_t level;
    smr_pkg::sample_t smp;
    sent = 0;
    while (sent < goal) begin
      if ($urandom_range(99) < 3) drain_results();
      if ($urandom_range(99) < 6) begin
        offer_item(smr_pkg::sample_t'($urandom()), 1'b0, 1'b1);
        sent++;
      end else begin
        len = ($urandom_range(99) < 80) ? $urandom_range(6, 1) : $urandom_range(40, 7);
        flat = ($urandom_range(99) < 10);
        level = pick_sample();
        close_on_sample = 1'($urandom_range(1));
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(99) < 8)
            offer_item(smr_pkg::sample_t'($urandom()), 1'b0, 1'b0);
          smp = flat ? level : pick_sample();
          offer_item(smp, 1'b1, close_on_sample && (i == len - 1));
          sent++;
        end
        if (!close_on_sample) begin
          offer_item(smr_pkg::sample_t'($urandom()), 1'b0, 1'b1);
          sent++;
        end
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    int unsigned hold_left;
    logic        hold_used;
    hold_left = 0;
    hold_used = 1'b0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (phase == PH_HOLD && !hold_used) begin
        hold_used = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    stats_t want;
    if (out_if.valid && out_if.ready) begin
      if (pending_stats.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result %0d: mean %h spread %h status %0d count %0d",
                   results_seen, out_if.mean_value, out_if.spread_value,
                   out_if.status, out_if.sample_count);
      end else begin
        want = pending_stats.pop_front();
        if (out_if.mean_value !== want.mean || out_if.spread_value !== want.spread ||
            out_if.status !== want.status || out_if.sample_count !== want.count) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display({"result %0d: mean exp %h got %h, spread exp %h got %h, ",
                      "status exp %0d got %0d, count exp %0d got %0d"},
                     results_seen, want.mean, out_if.mean_value,
                     want.spread, out_if.spread_value, want.status, out_if.status,
                     want.count, out_if.sample_count);
        end
      end
      results_seen++;
    end
    if (in_if.valid && in_if.ready)
      predict_stats(in_if.sample, in_if.has_sample, in_if.last);
  end

  initial begin
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    in_if.valid      = 1'b0;
    in_if.sample     = '0;
    in_if.has_sample = 1'b0;
    in_if.last       = 1'b0;
    rst_n            = 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (DIR_TABLE[i]) begin
      if (DIR_TABLE[i].typed) begin
        typed_stats   = DIR_TABLE[i].res;
        typed_pending = 1'b1;
      end
      offer_item(DIR_TABLE[i].smp, DIR_TABLE[i].has, DIR_TABLE[i].fin);
    end
    drain_results();

    phase = PH_FREE;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    send_random_sets(380);
    drain_results();

    phase = PH_TX_IDLE;
    tx_idle_pct = 87;
    rx_stall_pct = 0;
    send_random_sets(380);
    drain_results();

    phase = PH_RX_STALL;
    tx_idle_pct = 0;
    rx_stall_pct = 87;
    send_random_sets(380);
    drain_results();

    phase = PH_BOTH;
    tx_idle_pct = 10;
    rx_stall_pct = 10;
    send_random_sets(370);
    drain_results();

    phase = PH_HOLD;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    for (int k = 0; k < 14; k++) begin
      offer_item(pick_sample(), 1'b1, 1'b0);
      offer_item(pick_sample(), 1'b1, 1'b0);
      offer_item(pick_sample(), 1'b1, 1'b1);
    end
    drain_results();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_stats.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
